FILE: hdl/radar_frame_parser_unit_defines.svh
// assertion macros shared by the radar frame parser rtl
`ifndef RADAR_FRAME_PARSER_UNIT_DEFINES_SVH
`define RADAR_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define RFP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfp check failed: same-cycle implication");

// next-cycle implication, clocked on clk, off while rst_n is low
`define RFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfp check failed: next-cycle implication");

`endif

FILE: hdl/rfp_pkg.sv
// types, constants and helpers of the radar frame parser
package rfp_pkg;

    localparam int BYTE_W          = 8;
    localparam int DIST_W          = 16;
    localparam int MAX_FRAME_BYTES = 64;
    localparam int LEN_W           = 7;

    localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'hF4;
    localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'hF3;
    localparam logic [BYTE_W-1:0] HDR_BYTE2 = 8'hF2;
    localparam logic [BYTE_W-1:0] HDR_BYTE3 = 8'hF1;

    localparam logic [31:0] TAIL_WORD  = 32'hF8F7F6F5;
    localparam logic [23:0] HDR_RECENT = 24'hF3F2F1;

    localparam logic [LEN_W-1:0] LEN_AFTER_HDR = 7'd4;
    localparam logic [LEN_W-1:0] POS_STATE     = 7'd6;
    localparam logic [LEN_W-1:0] POS_DIST_LO   = 7'd7;
    localparam logic [LEN_W-1:0] POS_DIST_HI   = 7'd8;
    localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_FRAME_BYTES);

    localparam logic [1:0] HDR_LAST_IDX = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] target_state;
        logic [DIST_W-1:0] distance_cm;
        logic              presence;
    } rfp_result_t;

    // expected header byte for the given match count
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            2'd0:    b = HDR_BYTE0;
            2'd1:    b = HDR_BYTE1;
            2'd2:    b = HDR_BYTE2;
            default: b = HDR_BYTE3;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/rfp_if.sv
// stream interfaces of the radar frame parser: byte input and result output
interface rfp_byte_if;
    import rfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfp_result_if;
    import rfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] target_state;
    logic [DIST_W-1:0] distance_cm;
    logic              presence;

    modport source (output valid, output target_state, output distance_cm,
                    output presence, input ready);
    modport sink   (input valid, input target_state, input distance_cm,
                    input presence, output ready);
endinterface

FILE: hdl/rfp_parser.sv
// header hunt, frame counting, field capture and tail detection
`include "radar_frame_parser_unit_defines.svh"

module rfp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output logic                  emit,
    output rfp_pkg::rfp_result_t  result
);
    import rfp_pkg::*;

    logic [1:0]        hm_reg,        hm_next;
    logic              in_frame_reg,  in_frame_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic [23:0]       recent_reg,    recent_next;
    logic [BYTE_W-1:0] cap_state_reg, cap_state_next;
    logic [BYTE_W-1:0] cap_dlo_reg,   cap_dlo_next;
    logic [BYTE_W-1:0] cap_dhi_reg,   cap_dhi_next;
    logic [31:0]       last4;
    logic              tail_hit;

    always_comb
    begin
        hm_next        = hm_reg;
        in_frame_next  = in_frame_reg;
        len_next       = len_reg;
        recent_next    = recent_reg;
        cap_state_next = cap_state_reg;
        cap_dlo_next   = cap_dlo_reg;
        cap_dhi_next   = cap_dhi_reg;
        last4          = {recent_reg, rx_byte};
        tail_hit       = 1'b0;

        if (step)
        begin
            if (!in_frame_reg)
            begin
                // mismatch restarts the hunt without rechecking this byte
                if (rx_byte == hdr_byte(hm_reg))
                begin
                    if (hm_reg == HDR_LAST_IDX)
                    begin
                        hm_next       = 2'd0;
                        in_frame_next = 1'b1;
                        len_next      = LEN_AFTER_HDR;
                        recent_next   = HDR_RECENT;
                    end
                    else
                    begin
                        hm_next = hm_reg + 2'd1;
                    end
                end
                else
                begin
                    hm_next = 2'd0;
                end
            end
            else
            begin
                if (len_reg == POS_STATE)   cap_state_next = rx_byte;
                if (len_reg == POS_DIST_LO) cap_dlo_next   = rx_byte;
                if (len_reg == POS_DIST_HI) cap_dhi_next   = rx_byte;
                len_next    = len_reg + 7'd1;
                recent_next = last4[23:0];
                tail_hit    = (last4 == TAIL_WORD);
                if (tail_hit || len_next >= MAX_LEN)
                    in_frame_next = 1'b0;
            end
        end
    end

    // captures on the tail byte itself already count
    assign emit                = tail_hit;
    assign result.target_state = cap_state_next;
    assign result.distance_cm  = {cap_dhi_next, cap_dlo_next};
    assign result.presence     = (cap_state_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hm_reg        <= '0;
            in_frame_reg  <= 1'b0;
            len_reg       <= '0;
            recent_reg    <= '0;
            cap_state_reg <= '0;
            cap_dlo_reg   <= '0;
            cap_dhi_reg   <= '0;
        end
        else
        begin
            hm_reg        <= hm_next;
            in_frame_reg  <= in_frame_next;
            len_reg       <= len_next;
            recent_reg    <= recent_next;
            cap_state_reg <= cap_state_next;
            cap_dlo_reg   <= cap_dlo_next;
            cap_dhi_reg   <= cap_dhi_next;
        end
    end

    `RFP_ASSERT_IMPLY(a_len_in_range, in_frame_reg, (len_reg >= LEN_AFTER_HDR) && (len_reg < MAX_LEN))
    `RFP_ASSERT_IMPLY(a_hunt_idle_in_frame, in_frame_reg, hm_reg == 2'd0)
    `RFP_ASSERT_IMPLY(a_emit_needs_frame, emit, step && in_frame_reg)
    `RFP_ASSERT_NEXT(a_emit_ends_frame, emit, !in_frame_reg)

endmodule

FILE: hdl/radar_frame_parser_unit.sv
// radar frame parser top level: byte stream in, registered result stream out
//
// usage
//   rx  : one received radar byte per beat (rx_byte)
//   res : one beat per complete frame: target_state, distance_cm (little-endian
//         bytes 7 and 8) and presence (target_state nonzero)
//   the parser hunts for header F4 F3 F2 F1, counts frame bytes, keeps bytes
//   6, 7 and 8, and reports when the last four bytes are F8 F7 F6 F5; a frame
//   that reaches 64 bytes without a tail is dropped with no result
// timing
//   one byte per cycle while rx.ready is high; parser state updates on the
//   accepting edge and the result lands in the output register at that same
//   edge, so res.valid rises in the cycle after the final tail beat is taken
// reset
//   rst_n low clears the hunt state, the frame counter, the captured fields
//   and the output valid flag; no result is pending after reset
// backpressure
//   a result held in the output register while res.ready is low stalls rx
//   only then; with the register empty, or being drained in the same cycle,
//   rx.ready stays high
`include "radar_frame_parser_unit_defines.svh"

module radar_frame_parser_unit (
    input  logic     clk,
    input  logic     rst_n,
    rfp_byte_if.sink     rx,
    rfp_result_if.source res
);
    import rfp_pkg::*;

    logic        step;
    logic        emit;
    rfp_result_t result;

    logic        out_valid_reg, out_valid_next;
    rfp_result_t out_data_reg,  out_data_next;

    // take a byte whenever the output register is free or draining
    assign rx.ready = !out_valid_reg || res.ready;
    assign step     = rx.valid && rx.ready;

    rfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx.rx_byte),
        .emit    (emit),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // payload register needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.target_state = out_data_reg.target_state;
    assign res.distance_cm  = out_data_reg.distance_cm;
    assign res.presence     = out_data_reg.presence;

    `RFP_ASSERT_NEXT(a_result_loaded, step && emit, out_valid_reg)
    `RFP_ASSERT_NEXT(a_stall_keeps_result, out_valid_reg && !res.ready, out_valid_reg)
    `RFP_ASSERT_IMPLY(a_presence_matches, out_valid_reg, res.presence == (res.target_state != '0))

endmodule

FILE: bench/rfp_frame_checker.sv
// checker for the radar frame parser: predicts results from accepted bytes and compares them
module rfp_frame_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    input  logic                       rx_ready,
    input  logic [rfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  logic [rfp_pkg::BYTE_W-1:0] res_target_state,
    input  logic [rfp_pkg::DIST_W-1:0] res_distance_cm,
    input  logic                       res_presence,
    output int                         fail_count,
    output int                         pending
);
    import rfp_pkg::*;

    // predictor state
    logic [1:0]        hunt_idx;
    logic              collecting;
    logic [LEN_W-1:0]  byte_count;
    logic [23:0]       last_three;
    logic [BYTE_W-1:0] cap_state;
    logic [BYTE_W-1:0] cap_dist_lo;
    logic [BYTE_W-1:0] cap_dist_hi;

    logic [BYTE_W-1:0] header_seq [4];
    rfp_result_t       expected_reports [$];

    initial
    begin
        header_seq[0] = HDR_BYTE0;
        header_seq[1] = HDR_BYTE1;
        header_seq[2] = HDR_BYTE2;
        header_seq[3] = HDR_BYTE3;
    end

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        logic [31:0] window;
        rfp_result_t report;
        if (!collecting)
        begin
            // a mismatch drops back to zero without testing this byte as a new first byte
            if (b == header_seq[hunt_idx])
            begin
                if (hunt_idx == HDR_LAST_IDX)
                begin
                    hunt_idx   = 2'd0;
                    collecting = 1'b1;
                    byte_count = LEN_AFTER_HDR;
                    last_three = HDR_RECENT;
                end
                else
                    hunt_idx = hunt_idx + 2'd1;
            end
            else
                hunt_idx = 2'd0;
        end
        else
        begin
            if (byte_count == POS_STATE)
                cap_state = b;
            if (byte_count == POS_DIST_LO)
                cap_dist_lo = b;
            if (byte_count == POS_DIST_HI)
                cap_dist_hi = b;
            byte_count = byte_count + 1'b1;
            window     = {last_three, b};
            last_three = window[23:0];
            if (window == TAIL_WORD)
            begin
                report.target_state = cap_state;
                report.distance_cm  = {cap_dist_hi, cap_dist_lo};
                report.presence     = (cap_state != '0);
                expected_reports.push_back(report);
                collecting = 1'b0;
            end
            if (byte_count >= MAX_LEN)
                collecting = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rfp_result_t want;
        if (!rst_n)
        begin
            hunt_idx    = 2'd0;
            collecting  = 1'b0;
            byte_count  = '0;
            last_three  = '0;
            cap_state   = '0;
            cap_dist_lo = '0;
            cap_dist_hi = '0;
            expected_reports.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
                parse_byte(rx_byte);
            if (res_valid && res_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result beat: target_state %0h distance_cm %0h presence %0b",
                           res_target_state, res_distance_cm, res_presence);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (res_target_state !== want.target_state)
                    begin
                        $error("target_state: expected %0h, got %0h",
                               want.target_state, res_target_state);
                        fail_count++;
                    end
                    if (res_distance_cm !== want.distance_cm)
                    begin
                        $error("distance_cm: expected %0h, got %0h",
                               want.distance_cm, res_distance_cm);
                        fail_count++;
                    end
                    if (res_presence !== want.presence)
                    begin
                        $error("presence: expected %0b, got %0b",
                               want.presence, res_presence);
                        fail_count++;
                    end
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

FILE: bench/tb_radar_frame_parser_unit.sv
// testbench top for the radar frame parser: byte stimulus, result backpressure and verdict
module tb_radar_frame_parser_unit;
    import rfp_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TOTAL_BYTES      = 850;

    logic clk;
    logic rst_n;

    // both channels live in the rtl's own interfaces
    rfp_byte_if   rx_ch ();
    rfp_result_if res_ch ();

    int  fail_count;
    int  pending;
    int  sent_bytes;
    bit  steady;         // set for stretches with no random idling on either side
    bit  long_hold_req;  // asks the receiver for one long hold-off

    radar_frame_parser_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // the checker watches both channels; the top only makes stimulus
    rfp_frame_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_valid         (rx_ch.valid),
        .rx_ready         (rx_ch.ready),
        .rx_byte          (rx_ch.rx_byte),
        .res_valid        (res_ch.valid),
        .res_ready        (res_ch.ready),
        .res_target_state (res_ch.target_state),
        .res_distance_cm  (res_ch.distance_cm),
        .res_presence     (res_ch.presence),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // random byte biased toward the header and tail values so that stray
    // delimiters, broken headers and accidental tails come up often
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 3) == 0)
            return HDR_BYTE3 + BYTE_W'($urandom_range(0, 7));
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    // one beat on rx: optional idle first, then hold valid until taken.
    // inputs change only at the falling edge; acceptance is seen at the rising edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            rx_ch.valid = 1'b0;
            rx_ch.rx_byte = pick_byte();
        end
        @(negedge clk);
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sent_bytes++;
    endtask

    task automatic send_header();
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(HDR_BYTE2);
        send_byte(HDR_BYTE3);
    endtask

    task automatic send_tail();
        send_byte(TAIL_WORD[31:24]);
        send_byte(TAIL_WORD[23:16]);
        send_byte(TAIL_WORD[15:8]);
        send_byte(TAIL_WORD[7:0]);
    endtask

    // header, body bytes from position 4 on with state and distance placed
    // at positions 6..8 when the body reaches them, then the tail
    task automatic send_frame(input int body_len, input logic [BYTE_W-1:0] st,
                              input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
        int pos;
        send_header();
        for (pos = 4; pos < 4 + body_len; pos++)
        begin
            if (pos == int'(POS_STATE))
                send_byte(st);
            else if (pos == int'(POS_DIST_LO))
                send_byte(lo);
            else if (pos == int'(POS_DIST_HI))
                send_byte(hi);
            else
                send_byte(pick_byte());
        end
        send_tail();
    endtask

    // mostly well-formed frames with random content, plus noise, broken
    // headers, frames ending exactly at the length limit and overlong frames
    task automatic send_random_frame();
        int roll;
        int n;
        logic [BYTE_W-1:0] st;
        roll = $urandom_range(0, 99);
        st = ($urandom_range(0, 4) == 0) ? pick_byte() : BYTE_W'($urandom_range(0, 3));
        repeat ($urandom_range(0, 2))
            send_byte(pick_byte());
        if (roll < 65)
            send_frame($urandom_range(0, 8), st, pick_byte(), pick_byte());
        else if (roll < 78)
            send_frame($urandom_range(9, 20), st, pick_byte(), pick_byte());
        else if (roll < 83)
            // tail lands on the very byte that reaches the limit
            send_frame(MAX_FRAME_BYTES - 8, st, pick_byte(), pick_byte());
        else if (roll < 88)
        begin
            // no tail: dropped at the limit, then a good frame must still parse
            send_header();
            repeat (MAX_FRAME_BYTES - 4 + $urandom_range(0, 4))
                send_byte(BYTE_W'($urandom_range(0, 255)));
            send_frame($urandom_range(0, 8), st, pick_byte(), pick_byte());
        end
        else
        begin
            // header cut short, then random bytes
            n = $urandom_range(1, 3);
            send_byte(HDR_BYTE0);
            if (n > 1)
                send_byte(HDR_BYTE1);
            if (n > 2)
                send_byte(HDR_BYTE2);
            repeat ($urandom_range(1, 6))
                send_byte(pick_byte());
        end
    endtask

    // result side: random stalls, a steady mode, and one long hold-off on request
    initial
    begin
        int stall_left;
        res_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_ch.ready  = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                if (!steady && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        steady        = 1'b0;
        long_hold_req = 1'b0;
        sent_bytes    = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // shortest frame straight after reset: the tail fills positions 4..7,
        // so state and low distance are captured from tail bytes and the high
        // distance byte keeps its reset value
        send_frame(0, 8'h00, 8'h00, 8'h00);
        // repeated first header byte: the second one is not rechecked, so this
        // whole run of bytes must not open a frame
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(HDR_BYTE2);
        send_byte(HDR_BYTE3);
        // field extremes: no target, largest distance
        send_frame(5, 8'h00, 8'hFF, 8'hFF);

        while (sent_bytes < 300)
            send_random_frame();

        // long receiver hold-off while the sender keeps offering full-speed
        // frames: the output register fills and rx must stall
        steady        = 1'b1;
        long_hold_req = 1'b1;
        repeat (6)
            send_frame($urandom_range(0, 8), BYTE_W'($urandom_range(0, 3)),
                       pick_byte(), pick_byte());
        steady = 1'b0;

        // sender pause until every expected result is out
        @(negedge clk);
        rx_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (3)
            @(negedge clk);

        // back-to-back stretch with no idling on either side
        steady = 1'b1;
        while (sent_bytes < 450)
            send_random_frame();
        steady = 1'b0;

        while (sent_bytes < TOTAL_BYTES)
            send_random_frame();

        @(negedge clk);
        rx_ch.valid = 1'b0;

        // drain, then wait for any stray result beat
        wait (pending == 0);
        repeat (10)
            @(posedge clk);

        if (fail_count == 0)
            $display("tb_radar_frame_parser_unit: done, clean");
        else
            $display("tb_radar_frame_parser_unit: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #(2 * HALF_PERIOD * 500000);
        $display("tb_radar_frame_parser_unit: done, errors");
        $finish;
    end

endmodule
